FILE: src/lkvc_pkg.sv
// Package for the LRU key-value cache: request codes, reset and miss constants.
// No dependencies; used by the top level and by its port checker.
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CAP_W-1:0]  cap_t;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_t;

    localparam data_t MISS_VALUE = '1;     // -1
    localparam cap_t  CAP_RESET  = 5'd16;

endpackage

FILE: src/lru_key_value_cache_top.sv
// A get accepted on s_ passes through the input register and then the result register before it shows on m_.
// Throughput: one request per cycle; a put never waits on the result side, a get waits
// only while the result register holds an untaken transaction.
// Reset (aresetn low, synchronous): all entries invalid, ranks and live count zero,
// capacity 16, both registers empty. No clearing pass; keys and values are not reset.
// Depends on lkvc_pkg.
module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  lkvc_pkg::cap_t         cfg_wr_data,   // capacity_in_use
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,       // [31:0] key, [63:32] value
    input  logic                   s_tuser,       // [0] req_type
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,       // [31:0] read_value
    output logic                   m_tuser        // [0] hit
);

    localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (LW > lkvc_pkg::CAP_W) ? LW : lkvc_pkg::CAP_W;

    typedef logic [RW-1:0] rank_t;
    typedef logic [LW-1:0] count_t;
    typedef logic [CW-1:0] capx_t;

    // input register
    logic                in_valid_reg;
    lkvc_pkg::req_t      in_req_reg;
    lkvc_pkg::key_t      in_key_reg;
    lkvc_pkg::data_t     in_value_reg;

    // cache state
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    lkvc_pkg::key_t         key_reg   [MAX_ENTRIES];
    lkvc_pkg::data_t        value_reg [MAX_ENTRIES];
    rank_t                  rank_reg  [MAX_ENTRIES];
    rank_t                  rank_next [MAX_ENTRIES];
    count_t                 live_reg, live_next;
    lkvc_pkg::cap_t         cap_reg;

    // result register
    logic                out_valid_reg;
    logic                out_hit_reg;
    lkvc_pkg::data_t     out_data_reg;

    logic out_free, proceed, accept, is_put;
    logic [MAX_ENTRIES-1:0] match, victim, valid_after, free, new_slot;
    logic                   hit, full, inserting;
    lkvc_pkg::data_t        hit_value;
    rank_t                  hit_rank;
    capx_t                  cap_x, cap_eff;

    assign is_put   = (in_req_reg == lkvc_pkg::REQ_PUT);
    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = in_valid_reg && (is_put || out_free);
    assign s_tready = !in_valid_reg || proceed;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_data_reg;

    // parallel lookup; live keys are unique so match is one-hot or zero
    always_comb begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (match[i]) begin
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank  | rank_reg[i];
            end
        end
        hit = |match;
    end

    // capacity clamped to 1..MAX_ENTRIES
    always_comb begin
        cap_x = CW'(cap_reg);
        if (cap_x == '0)
            cap_eff = CW'(1);
        else if (cap_x > CW'(MAX_ENTRIES))
            cap_eff = CW'(MAX_ENTRIES);
        else
            cap_eff = cap_x;
        full = (CW'(live_reg) >= cap_eff);
    end

    // ranks of live entries run 0..live-1, so the oldest holds live-1
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            victim[i] = full && valid_reg[i] && (LW'(rank_reg[i]) == live_reg - LW'(1));
        valid_after = valid_reg & ~victim;
        free        = ~valid_after;
        new_slot    = free & (~free + MAX_ENTRIES'(1));   // lowest free slot
        inserting   = proceed && is_put && !hit && (|free);
    end

    always_comb begin
        valid_next = valid_reg;
        live_next  = live_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
            rank_next[i] = rank_reg[i];
        if (proceed && hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (match[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
        end else if (inserting) begin
            valid_next = valid_after | new_slot;
            live_next  = live_reg - LW'(full) + LW'(1);
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (new_slot[i] || victim[i])
                    rank_next[i] = '0;
                else if (valid_after[i])
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            live_reg      <= '0;
            cap_reg       <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++)
                rank_reg[i] <= '0;
        end else begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (proceed)
                in_valid_reg <= 1'b0;

            if (proceed && !is_put)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;

            valid_reg <= valid_next;
            live_reg  <= live_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_req_reg   <= lkvc_pkg::req_t'(s_tuser);
            in_key_reg   <= s_tdata[31:0];
            in_value_reg <= s_tdata[63:32];
        end
        if (proceed && !is_put) begin
            out_hit_reg  <= hit;
            out_data_reg <= hit ? hit_value : lkvc_pkg::MISS_VALUE;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (proceed && is_put && (match[i] || (inserting && new_slot[i])))
                value_reg[i] <= in_value_reg;
            if (inserting && new_slot[i])
                key_reg[i] <= in_key_reg;
        end
    end

endmodule

FILE: src/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, attached by bind.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lkvc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a miss always reads back -1
    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == lkvc_pkg::MISS_VALUE)
        else $error("miss without -1");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input register is empty right after reset
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready after reset");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
